@@ rtl/core/base64_stream_codec_core_macros.svh @@
// Assertion macros shared by the Base64 stream codec core.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

// Property that must hold on every edge out of reset.
`define B64SC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, out of reset.
`define B64SC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/b64sc_pkg.sv @@
// Package for the Base64 stream codec: job type, job kinds, character codes
// and the alphabet mapping functions. No dependencies.
package b64sc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // job kinds handed from the front to the back
   localparam logic [1:0] JOB_ENC = 2'd0;
   localparam logic [1:0] JOB_DEC = 2'd1;
   localparam logic [1:0] JOB_ERR = 2'd2;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DIG_0 = 8'h30;
   localparam logic [7:0] CHAR_DIG_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // num: encode - index of the last alphabet char (rest are pads);
   //      decode - number of bytes minus one
   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] word;
      logic [1:0]  num;
      logic        last;
   } job_type;

   // unknown characters, pad included, map to zero
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         t = c - CHAR_UC_A;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         t = c - CHAR_LC_A + 8'd26;
      end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
         t = c - CHAR_DIG_0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         t = 8'd62;
      end else if (c == CHAR_SLASH) begin
         t = 8'd63;
      end
      return t[5:0];
   endfunction

   function automatic logic [7:0] alpha_char(input logic [5:0] s);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, s};
      if (w < 8'd26) begin
         c = CHAR_UC_A + w;
      end else if (w < 8'd52) begin
         c = CHAR_LC_A + w - 8'd26;
      end else if (w < 8'd62) begin
         c = CHAR_DIG_0 + w - 8'd52;
      end else if (w == 8'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

@@ rtl/core/b64sc_if.sv @@
// Valid/ready channel interfaces for the Base64 stream codec.
// Request carries one input beat, response one result beat. No dependencies.
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       out_error;

   modport source (output valid, output out_byte, output out_last, output out_error,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input out_error,
                   output ready);
endinterface

@@ rtl/core/b64sc_front.sv @@
// Front end: accepts request beats, gathers groups/quads and issues jobs.
// Depends on b64sc_pkg, b64sc_req_if and the core macro header.
`include "base64_stream_codec_core_macros.svh"

module b64sc_front import b64sc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   b64sc_req_if.sink   req_chan,
   input  logic        csr_we,
   input  logic        csr_wdata,
   output logic        push,
   output job_type     push_job,
   input  logic        queue_ready
);

   logic        mode_ff;
   logic [23:0] group_accum_ff, group_accum_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [1:0]  pad_count_ff, pad_count_in;

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic [23:0] enc_accum;
   logic [2:0]  enc_cnt;
   logic [23:0] dec_accum;
   logic [1:0]  dec_pad;

   assign req_chan.ready = queue_ready;
   assign accept = req_chan.valid && queue_ready;
   assign b      = req_chan.in_byte;
   assign last   = req_chan.in_last;

   assign enc_accum = {group_accum_ff[15:0], b};
   assign enc_cnt   = {1'b0, group_count_ff} + 3'd1;
   assign dec_accum = {group_accum_ff[17:0], sextet_of(b)};
   assign dec_pad   = (b != CHAR_PAD)         ? 2'd0 :
                      (pad_count_ff == 2'd3)  ? 2'd3 : pad_count_ff + 2'd1;

   always_comb begin
      group_accum_in = group_accum_ff;
      group_count_in = group_count_ff;
      pad_count_in   = pad_count_ff;
      push           = 1'b0;
      push_job       = '0;
      if (accept) begin
         if (!mode_ff) begin
            if (enc_cnt < 3'd3 && !last) begin
               group_accum_in = enc_accum;
               group_count_in = enc_cnt[1:0];
            end else begin
               push          = 1'b1;
               push_job.kind = JOB_ENC;
               push_job.num  = enc_cnt[1:0];
               push_job.last = last;
               // left-align a partial group, zero-filled
               case (enc_cnt[1:0])
                  2'd1:    push_job.word = {enc_accum[7:0], 16'h0000};
                  2'd2:    push_job.word = {enc_accum[15:0], 8'h00};
                  default: push_job.word = enc_accum;
               endcase
               group_accum_in = '0;
               group_count_in = '0;
               pad_count_in   = '0;
            end
         end else if (group_count_ff != 2'd3) begin
            if (last) begin
               push           = 1'b1;
               push_job.kind  = JOB_ERR;
               push_job.last  = 1'b1;
               group_accum_in = '0;
               group_count_in = '0;
               pad_count_in   = '0;
            end else begin
               group_accum_in = dec_accum;
               group_count_in = group_count_ff + 2'd1;
               pad_count_in   = dec_pad;
            end
         end else begin
            push          = 1'b1;
            push_job.word = dec_accum;
            push_job.last = last;
            if (!last) begin
               push_job.kind = JOB_DEC;
               push_job.num  = 2'd2;
            end else if (dec_pad == 2'd3) begin
               push_job.kind = JOB_ERR;
               push_job.word = '0;
            end else begin
               push_job.kind = JOB_DEC;
               push_job.num  = 2'd2 - dec_pad;
            end
            group_accum_in = '0;
            group_count_in = '0;
            pad_count_in   = '0;
         end
      end
      // mode write restarts the group
      if (csr_we) begin
         group_accum_in = '0;
         group_count_in = '0;
         pad_count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         group_accum_ff <= '0;
         group_count_ff <= '0;
         pad_count_ff   <= '0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         group_accum_ff <= group_accum_in;
         group_count_ff <= group_count_in;
         pad_count_ff   <= pad_count_in;
      end
   end

   `B64SC_ASSERT_IMPL(a_enc_count, !mode_ff, group_count_ff != 2'd3, "encode group overran")
   `B64SC_ASSERT(a_pad_le_count, pad_count_ff <= group_count_ff, "pad count exceeds quad fill")

endmodule

@@ rtl/core/b64sc_queue.sv @@
// Short job queue between the front and back ends of the Base64 codec.
// Depends on b64sc_pkg and the core macro header.
`include "base64_stream_codec_core_macros.svh"

module b64sc_queue import b64sc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign ready      = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign push_ok    = push && ready;
   assign pop_ok     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push_ok ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `B64SC_ASSERT(a_count_range, count_ff <= QCNT_W'(QUEUE_DEPTH), "job queue count out of range")
   `B64SC_ASSERT_IMPL(a_no_overflow, push, ready, "job pushed into a full queue")

endmodule

@@ rtl/core/b64sc_back.sv @@
// Back end: expands queued jobs into result beats, one per cycle while rsp_chan is ready,
// through a registered output stage. Depends on b64sc_pkg, b64sc_rsp_if and macros.
`include "base64_stream_codec_core_macros.svh"

module b64sc_back import b64sc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   b64sc_rsp_if.source rsp_chan
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       err_ff;

   logic       load;
   logic       final_beat;
   logic [7:0] res_byte;
   logic       res_last;
   logic       res_err;
   logic [5:0] sx;
   logic [7:0] dec_byte;

   assign load = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop  = load && final_beat;

   always_comb begin
      case (idx_ff)
         2'd0:    sx = head_job.word[23:18];
         2'd1:    sx = head_job.word[17:12];
         2'd2:    sx = head_job.word[11:6];
         default: sx = head_job.word[5:0];
      endcase
      case (idx_ff)
         2'd0:    dec_byte = head_job.word[23:16];
         2'd1:    dec_byte = head_job.word[15:8];
         default: dec_byte = head_job.word[7:0];
      endcase
   end

   always_comb begin
      unique case (head_job.kind)
         JOB_ENC: begin
            res_byte   = (idx_ff <= head_job.num) ? alpha_char(sx) : CHAR_PAD;
            final_beat = (idx_ff == 2'd3);
            res_last   = head_job.last && final_beat;
            res_err    = 1'b0;
         end
         JOB_DEC: begin
            res_byte   = dec_byte;
            final_beat = (idx_ff == head_job.num);
            res_last   = head_job.last && final_beat;
            res_err    = 1'b0;
         end
         default: begin
            res_byte   = 8'h00;
            final_beat = 1'b1;
            res_last   = 1'b1;
            res_err    = 1'b1;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = final_beat ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= res_byte;
         last_ff <= res_last;
         err_ff  <= res_err;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.out_last  = last_ff;
   assign rsp_chan.out_error = err_ff;

   `B64SC_ASSERT_IMPL(a_job_held, idx_ff != 2'd0, head_valid, "job left mid-expansion")
   `B64SC_ASSERT_IMPL(a_err_is_last, rsp_valid_ff && err_ff, last_ff, "error beat not last")

endmodule

@@ rtl/core/base64_stream_codec_core.sv @@
// Base64 stream codec (standard alphabet). In encode mode (csr_wdata 0) each group of three
// bytes, or the shorter final group of a message, leaves as four characters with '=' padding;
// in decode mode (csr_wdata 1) each quad of characters leaves as up to three bytes, and a
// message that ends inside a quad or with three or more pads gives a single error beat.
// Unknown characters decode as zero. A request beat is taken every cycle while the two-entry
// job queue has room; results leave one per cycle from the back end while rsp_chan is ready,
// so the sustained rate is set by the single-wide result port: four result beats per three
// bytes when encoding, three per four characters when decoding. Results pass the job queue,
// then the output stage. Write csr only while the core is idle; a write restarts the group.
// Depends on b64sc_pkg, b64sc_if, b64sc_front, b64sc_queue and b64sc_back.
module base64_stream_codec_core import b64sc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   b64sc_req_if.sink   req_chan,
   b64sc_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic    push;
   job_type push_job;
   logic    queue_ready;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   b64sc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .push_job    (push_job),
      .queue_ready (queue_ready)
   );

   b64sc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .ready      (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64sc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
